// File: design/assert_macros.svh
// Assertion helpers for the port checker in design/mhp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, quiet while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that an implication holds whenever a qualifying condition is true.
`define ASSERT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// File: design/mhp_pkg.sv
`default_nettype none

package mhp_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] CFG_PAN_ID       = 2'd0;
	localparam logic [1:0] CFG_AUX_HEADER   = 2'd1;
	localparam logic [1:0] CFG_EXPLICIT_KEY = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FOREIGN   = 3'd1;
	localparam logic [2:0] ST_BAD_MODE  = 3'd2;
	localparam logic [2:0] ST_BCAST_SRC = 3'd3;
	localparam logic [2:0] ST_BAD_KEY   = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	// addressing modes
	localparam logic [1:0] AM_NONE     = 2'd0;
	localparam logic [1:0] AM_RESERVED = 2'd1;
	localparam logic [1:0] AM_SHORT    = 2'd2;
	localparam logic [1:0] AM_LONG     = 2'd3;

	localparam logic [15:0] BROADCAST = 16'hFFFF;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  frame_type;
		logic        pending;
		logic        ack_request;
		logic [7:0]  seq_num;
		logic [63:0] dst_addr;
		logic [63:0] src_addr;
		logic [2:0]  sec_level;
		logic        key_mode;
		logic [7:0]  key_index;
		logic [31:0] frame_counter;
		logic [4:0]  hdr_bytes;
	} hdr_item_t;

	typedef struct packed {
		logic [15:0] pan_id;
		logic        aux_header_on;
		logic        explicit_keys_on;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/mhp_in_stage.sv
`default_nettype none

// Input register: hold one received byte until the parser advances.
module mhp_in_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire mhp_pkg::byte_item_t byte_data,
	input  wire logic                advance,
	output logic                     valid_s1,
	output mhp_pkg::byte_item_t      data_s1
);

	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= byte_data;
		end
	end

endmodule

`default_nettype wire

// File: design/mhp_parser.sv
`default_nettype none

// Header decode state machine: consume one byte per step, report a result when
// the header concludes, an error shows up or the frame ends early.
module mhp_parser #(
	parameter int unsigned ADDR_BYTES = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           rx_last,
	input  wire mhp_pkg::cfg_t  cfg,
	output logic                fire,
	output mhp_pkg::hdr_item_t  result
);

	localparam logic [3:0] PH_FC0    = 4'd0;
	localparam logic [3:0] PH_FC1    = 4'd1;
	localparam logic [3:0] PH_SEQ    = 4'd2;
	localparam logic [3:0] PH_DPAN   = 4'd3;
	localparam logic [3:0] PH_DADDR  = 4'd4;
	localparam logic [3:0] PH_SPAN   = 4'd5;
	localparam logic [3:0] PH_SADDR  = 4'd6;
	localparam logic [3:0] PH_SECCTL = 4'd7;
	localparam logic [3:0] PH_CNT    = 4'd8;
	localparam logic [3:0] PH_KEYIDX = 4'd9;
	localparam logic [3:0] PH_SKIP   = 4'd10;

	localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (8 * (8 - ADDR_BYTES));
	localparam bit          SHORT_ONLY = (ADDR_BYTES == 2);
	localparam bit          LONG_ONLY  = (ADDR_BYTES == 8);

	function automatic logic mode_bad(input logic [1:0] m);
		mode_bad = (m == mhp_pkg::AM_RESERVED) || (m == mhp_pkg::AM_LONG && SHORT_ONLY);
	endfunction

	function automatic logic [3:0] addr_len(input logic [1:0] m);
		addr_len = (m == mhp_pkg::AM_LONG) ? 4'd8 : 4'd2;
	endfunction

	logic [4:0]  pos_q,   pos_n;
	logic [3:0]  phase_q, phase_n;
	logic [7:0]  cb_q,    cb_n;
	logic [1:0]  dmode_q, dmode_n;
	logic [1:0]  smode_q, smode_n;
	logic [3:0]  fcnt_q,  fcnt_n;
	logic [63:0] coll_q,  coll_n;
	logic [7:0]  seq_q,   seq_n;
	logic [63:0] dst_q,   dst_n;
	logic [63:0] src_q,   src_n;
	logic [2:0]  level_q, level_n;
	logic        kmode_q, kmode_n;
	logic [7:0]  kidx_q,  kidx_n;
	logic [31:0] cntr_q,  cntr_n;

	logic        sec_start;
	logic        src_res;
	logic [2:0]  src_code;
	logic [3:0]  src_ph;
	logic        res_hit;
	logic [2:0]  res_code;
	logic [63:0] coll_add;
	logic [3:0]  cnt_add;
	logic        active;

	// outcome of moving on to the source fields (valid once frame control is in)
	always_comb begin
		sec_start = cfg.aux_header_on && cb_q[3];
		src_res   = 1'b0;
		src_code  = mhp_pkg::ST_OK;
		src_ph    = PH_SKIP;
		if (smode_q == mhp_pkg::AM_NONE) begin
			if (sec_start) begin
				src_ph = PH_SECCTL;
			end else begin
				src_res = 1'b1;
			end
		end else if (!cb_q[6]) begin
			src_ph = PH_SPAN;
		end else if (mode_bad(smode_q)) begin
			src_res  = 1'b1;
			src_code = mhp_pkg::ST_BAD_MODE;
		end else begin
			src_ph = PH_SADDR;
		end
	end

	// collect the byte into the current field, least significant byte first
	always_comb begin
		coll_add = coll_q;
		for (int i = 0; i < 8; i++) begin
			if (fcnt_q[2:0] == 3'(i)) begin
				coll_add[8*i +: 8] = coll_q[8*i +: 8] | rx_byte;
			end
		end
		cnt_add = fcnt_q + 4'd1;
	end

	always_comb begin
		pos_n   = pos_q;
		phase_n = phase_q;
		cb_n    = cb_q;
		dmode_n = dmode_q;
		smode_n = smode_q;
		fcnt_n  = fcnt_q;
		coll_n  = coll_q;
		seq_n   = seq_q;
		dst_n   = dst_q;
		src_n   = src_q;
		level_n = level_q;
		kmode_n = kmode_q;
		kidx_n  = kidx_q;
		cntr_n  = cntr_q;
		res_hit  = 1'b0;
		res_code = mhp_pkg::ST_OK;
		active   = phase_q < PH_SKIP;

		if (active) begin
			pos_n = pos_q + 5'd1;
			unique case (phase_q)
				PH_FC0: begin
					cb_n    = rx_byte;
					phase_n = PH_FC1;
				end
				PH_FC1: begin
					dmode_n = rx_byte[3:2];
					smode_n = rx_byte[7:6];
					phase_n = PH_SEQ;
				end
				PH_SEQ: begin
					seq_n = rx_byte;
					if (dmode_q != mhp_pkg::AM_NONE) begin
						phase_n = PH_DPAN;
						fcnt_n  = 4'd0;
						coll_n  = '0;
					end else if (src_res) begin
						res_hit  = 1'b1;
						res_code = src_code;
					end else begin
						phase_n = src_ph;
						fcnt_n  = 4'd0;
						coll_n  = '0;
					end
				end
				PH_DPAN: begin
					fcnt_n = cnt_add;
					coll_n = coll_add;
					if (cnt_add >= 4'd2) begin
						if (coll_add[15:0] != cfg.pan_id &&
						    coll_add[15:0] != mhp_pkg::BROADCAST) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_FOREIGN;
						end else if (mode_bad(dmode_q)) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_BAD_MODE;
						end else begin
							phase_n = PH_DADDR;
							fcnt_n  = 4'd0;
							coll_n  = '0;
						end
					end
				end
				PH_DADDR: begin
					fcnt_n = cnt_add;
					coll_n = coll_add;
					if (cnt_add >= addr_len(dmode_q)) begin
						if (dmode_q == mhp_pkg::AM_SHORT &&
						    coll_add != {48'd0, mhp_pkg::BROADCAST} && LONG_ONLY) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_BAD_MODE;
						end else begin
							if (dmode_q == mhp_pkg::AM_SHORT) begin
								dst_n = (coll_add == {48'd0, mhp_pkg::BROADCAST}) ?
									64'd0 : coll_add;
							end else begin
								dst_n = coll_add & ADDR_MASK;
							end
							if (src_res) begin
								res_hit  = 1'b1;
								res_code = src_code;
							end else begin
								phase_n = src_ph;
								fcnt_n  = 4'd0;
								coll_n  = '0;
							end
						end
					end
				end
				PH_SPAN: begin
					fcnt_n = cnt_add;
					coll_n = coll_add;
					if (cnt_add >= 4'd2) begin
						if (mode_bad(smode_q)) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_BAD_MODE;
						end else begin
							phase_n = PH_SADDR;
							fcnt_n  = 4'd0;
							coll_n  = '0;
						end
					end
				end
				PH_SADDR: begin
					fcnt_n = cnt_add;
					coll_n = coll_add;
					if (cnt_add >= addr_len(smode_q)) begin
						if (smode_q == mhp_pkg::AM_SHORT &&
						    coll_add == {48'd0, mhp_pkg::BROADCAST}) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_BCAST_SRC;
						end else if (smode_q == mhp_pkg::AM_SHORT && LONG_ONLY) begin
							res_hit  = 1'b1;
							res_code = mhp_pkg::ST_BAD_MODE;
						end else begin
							src_n = (smode_q == mhp_pkg::AM_SHORT) ? coll_add :
								(coll_add & ADDR_MASK);
							if (sec_start) begin
								phase_n = PH_SECCTL;
								fcnt_n  = 4'd0;
								coll_n  = '0;
							end else begin
								res_hit = 1'b1;
							end
						end
					end
				end
				PH_SECCTL: begin
					level_n = rx_byte[2:0];
					if (cfg.explicit_keys_on && rx_byte[4]) begin
						res_hit  = 1'b1;
						res_code = mhp_pkg::ST_BAD_KEY;
					end else begin
						if (cfg.explicit_keys_on) begin
							kmode_n = rx_byte[3];
						end
						phase_n = PH_CNT;
						fcnt_n  = 4'd0;
						coll_n  = '0;
					end
				end
				PH_CNT: begin
					fcnt_n = cnt_add;
					coll_n = coll_add;
					if (cnt_add >= 4'd4) begin
						cntr_n = coll_add[31:0];
						if (kmode_q) begin
							phase_n = PH_KEYIDX;
						end else begin
							res_hit = 1'b1;
						end
					end
				end
				PH_KEYIDX: begin
					kidx_n  = rx_byte;
					res_hit = 1'b1;
				end
				default: begin
					phase_n = PH_SKIP;
				end
			endcase
			if (res_hit) begin
				phase_n = PH_SKIP;
			end
		end
	end

	// result reflects the state after this byte, before any end-of-frame clear
	assign fire = step && active && (res_hit || rx_last);

	always_comb begin
		result.status        = res_hit ? res_code : mhp_pkg::ST_TRUNC;
		result.frame_type    = cb_n[2:0];
		result.pending       = cb_n[4];
		result.ack_request   = cb_n[5];
		result.seq_num       = seq_n;
		result.dst_addr      = dst_n;
		result.src_addr      = src_n;
		result.sec_level     = level_n;
		result.key_mode      = kmode_n;
		result.key_index     = kidx_n;
		result.frame_counter = cntr_n;
		result.hdr_bytes     = pos_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_FC0;
			cb_q    <= '0;
			dmode_q <= '0;
			smode_q <= '0;
			fcnt_q  <= '0;
			coll_q  <= '0;
			seq_q   <= '0;
			dst_q   <= '0;
			src_q   <= '0;
			level_q <= '0;
			kmode_q <= 1'b0;
			kidx_q  <= '0;
			cntr_q  <= '0;
		end else if (step) begin
			if (rx_last) begin
				pos_q   <= '0;
				phase_q <= PH_FC0;
				cb_q    <= '0;
				dmode_q <= '0;
				smode_q <= '0;
				fcnt_q  <= '0;
				coll_q  <= '0;
				seq_q   <= '0;
				dst_q   <= '0;
				src_q   <= '0;
				level_q <= '0;
				kmode_q <= 1'b0;
				kidx_q  <= '0;
				cntr_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				phase_q <= phase_n;
				cb_q    <= cb_n;
				dmode_q <= dmode_n;
				smode_q <= smode_n;
				fcnt_q  <= fcnt_n;
				coll_q  <= coll_n;
				seq_q   <= seq_n;
				dst_q   <= dst_n;
				src_q   <= src_n;
				level_q <= level_n;
				kmode_q <= kmode_n;
				kidx_q  <= kidx_n;
				cntr_q  <= cntr_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/mhp_out_stage.sv
`default_nettype none

// Result register: hold a decoded header until the consumer takes it.
module mhp_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire mhp_pkg::hdr_item_t result,
	output logic                    hdr_valid,
	input  wire logic               hdr_ready,
	output mhp_pkg::hdr_item_t      hdr_data,
	output logic                    can_load
);

	assign can_load = !hdr_valid || hdr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid <= 1'b0;
		end else if (load) begin
			hdr_valid <= 1'b1;
		end else if (hdr_ready) begin
			hdr_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_data <= result;
		end
	end

endmodule

`default_nettype wire

// File: design/mac_header_parser.sv
// Receive-side 802.15.4 MAC header parser. Frame bytes arrive one per transfer
// on the byte channel, header first, with last_byte set on the final byte. The
// block gives exactly one result transfer per frame on the hdr channel: when
// the header is complete (status ok), when an error is found (foreign PAN,
// bad addressing mode, broadcast source, bad key id mode) or when the frame
// ends before either (truncated). Bytes after that are dropped until the
// last byte, which rearms the parser. Throughput is one byte per clock when
// nothing stalls; the byte that causes a result goes through the input
// register, then the result register. The parser advances only while the
// result register is empty or being drained, so output back-pressure is the
// one thing that stalls the byte channel. The user must write configuration
// (PAN, auxiliary header and key parsing enables) through cfg_we/cfg_addr/
// cfg_data only while no frame is in flight; the block does not enforce this.
// There is no reset sweep and the block is ready as soon as reset is released.
// ADDR_BYTES (2 to 8) sets how many bytes of a long address are kept; at 2
// long addresses are rejected, at 8 non-broadcast short addresses are rejected.
`default_nettype none

module mac_header_parser #(
	parameter int unsigned ADDR_BYTES = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// received bytes
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire mhp_pkg::byte_item_t byte_data,
	// decoded headers
	output logic                     hdr_valid,
	input  wire logic                hdr_ready,
	output mhp_pkg::hdr_item_t       hdr_data,
	// configuration writes
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data
);

	mhp_pkg::cfg_t       cfg_q;
	mhp_pkg::byte_item_t data_s1;
	mhp_pkg::hdr_item_t  result;
	logic                valid_s1;
	logic                can_load;
	logic                advance;
	logic                fire;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_id           <= 16'hABCD;
			cfg_q.aux_header_on    <= 1'b1;
			cfg_q.explicit_keys_on <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mhp_pkg::CFG_PAN_ID:       cfg_q.pan_id           <= cfg_data;
				mhp_pkg::CFG_AUX_HEADER:   cfg_q.aux_header_on    <= cfg_data[0];
				mhp_pkg::CFG_EXPLICIT_KEY: cfg_q.explicit_keys_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the held byte whenever the result register can take a result.
	assign advance = valid_s1 && can_load;

	mhp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	mhp_parser #(
		.ADDR_BYTES (ADDR_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (data_s1.frame_byte),
		.rx_last (data_s1.last_byte),
		.cfg     (cfg_q),
		.fire    (fire),
		.result  (result)
	);

	mhp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr_data  (hdr_data),
		.can_load  (can_load)
	);

endmodule

`default_nettype wire

// File: design/mhp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mhp_port_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                byte_valid,
	input wire logic                byte_ready,
	input wire mhp_pkg::byte_item_t byte_data,
	input wire logic                hdr_valid,
	input wire logic                hdr_ready,
	input wire mhp_pkg::hdr_item_t  hdr_data
);

	logic ok_hdr;

	// a header offered on the hdr channel whose status reports it complete
	assign ok_hdr = hdr_valid && hdr_data.status == mhp_pkg::ST_OK;

	`ASSERT_CLK(a_byte_hold, byte_valid && !byte_ready |=> byte_valid && $stable(byte_data), "byte moved")
	`ASSERT_CLK(a_hold_stalled, hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_data), "result moved")
	`ASSERT_IMPLY(a_status_range, hdr_valid, hdr_data.status <= mhp_pkg::ST_TRUNC, "bad status code")
	`ASSERT_IMPLY(a_ok_len, ok_hdr, hdr_data.hdr_bytes >= 5'd3, "complete header too short")
	`ASSERT_IMPLY(a_key_index, hdr_valid && !hdr_data.key_mode, hdr_data.key_index == 8'd0, "stray key index")

endmodule

bind mac_header_parser mhp_port_checker u_chk (.*);

`default_nettype wire

// File: dv/mhp_checker.sv
// Watches both channels of the header parser, keeps its own copy of the parse
// state and registers, and compares each header transfer with the oldest one due.
module mhp_checker #(
	parameter int unsigned ADDR_BYTES = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	input  wire logic                byte_ready,
	input  wire mhp_pkg::byte_item_t byte_data,
	input  wire logic                hdr_valid,
	input  wire logic                hdr_ready,
	input  wire mhp_pkg::hdr_item_t  hdr_data,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_addr,
	input  wire logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                       fails,
	output int                       owed
);

	typedef enum logic [3:0] {
		AT_FC0, AT_FC1, AT_SEQ, AT_DPAN, AT_DADDR, AT_SPAN, AT_SADDR,
		AT_SECCTL, AT_COUNTER, AT_KEYIDX, AT_DONE
	} hdr_stage_t;

	localparam int GO_ON = -1;
	localparam logic [63:0] KEEP_MASK =
		(ADDR_BYTES >= 8) ? '1 : ((64'd1 << (8 * ADDR_BYTES)) - 64'd1);

	logic [15:0] pan_cfg;
	logic        aux_cfg, keys_cfg;

	hdr_stage_t  stage;
	logic [4:0]  pos;
	logic [7:0]  ctl;
	logic [1:0]  dmode, smode;
	logic [3:0]  fcount;
	logic [63:0] acc;
	logic [7:0]  seq_r, keyidx_r;
	logic [63:0] dst_r, src_r;
	logic [2:0]  level_r;
	logic        keymode_r;
	logic [31:0] counter_r;

	mhp_pkg::hdr_item_t headers_due[$];
	int                 hdr_seen;

	function automatic void clear_frame();
		stage = AT_FC0; pos = '0; ctl = '0; dmode = '0; smode = '0;
		fcount = '0; acc = '0; seq_r = '0; keyidx_r = '0; dst_r = '0;
		src_r = '0; level_r = '0; keymode_r = 1'b0; counter_r = '0;
	endfunction

	function automatic logic bad_mode(logic [1:0] m);
		return m == mhp_pkg::AM_RESERVED || (m == mhp_pkg::AM_LONG && ADDR_BYTES == 2);
	endfunction

	function automatic logic [3:0] addr_bytes_of(logic [1:0] m);
		return (m == mhp_pkg::AM_LONG) ? 4'd8 : 4'd2;
	endfunction

	function automatic void open_field(hdr_stage_t s);
		stage = s; fcount = '0; acc = '0;
	endfunction

	function automatic void gather(logic [7:0] b);
		acc = acc | ({56'd0, b} << (8 * fcount));
		fcount = fcount + 4'd1;
	endfunction

	function automatic int to_security();
		if (aux_cfg && ctl[3]) begin
			open_field(AT_SECCTL);
			return GO_ON;
		end
		return int'(mhp_pkg::ST_OK);
	endfunction

	function automatic int to_src_addr();
		if (bad_mode(smode))
			return int'(mhp_pkg::ST_BAD_MODE);
		open_field(AT_SADDR);
		return GO_ON;
	endfunction

	function automatic int to_source();
		if (smode == mhp_pkg::AM_NONE)
			return to_security();
		// without PAN compression the source PAN comes first and is skipped
		if (!ctl[6]) begin
			open_field(AT_SPAN);
			return GO_ON;
		end
		return to_src_addr();
	endfunction

	function automatic int to_dest();
		if (dmode == mhp_pkg::AM_NONE)
			return to_source();
		open_field(AT_DPAN);
		return GO_ON;
	endfunction

	// Advance the parse by one byte; a status when the frame concludes, else GO_ON.
	function automatic int parse_byte(logic [7:0] b);
		case (stage)
			AT_FC0: begin
				ctl = b;
				stage = AT_FC1;
				return GO_ON;
			end
			AT_FC1: begin
				dmode = b[3:2];
				smode = b[7:6];
				stage = AT_SEQ;
				return GO_ON;
			end
			AT_SEQ: begin
				seq_r = b;
				return to_dest();
			end
			AT_DPAN: begin
				gather(b);
				if (fcount < 4'd2)
					return GO_ON;
				if (acc[15:0] != pan_cfg && acc[15:0] != mhp_pkg::BROADCAST)
					return int'(mhp_pkg::ST_FOREIGN);
				if (bad_mode(dmode))
					return int'(mhp_pkg::ST_BAD_MODE);
				open_field(AT_DADDR);
				return GO_ON;
			end
			AT_DADDR: begin
				gather(b);
				if (fcount < addr_bytes_of(dmode))
					return GO_ON;
				if (dmode == mhp_pkg::AM_SHORT) begin
					if (acc[15:0] == mhp_pkg::BROADCAST)
						dst_r = '0;
					else if (ADDR_BYTES == 8)
						return int'(mhp_pkg::ST_BAD_MODE);
					else
						dst_r = acc;
				end else begin
					dst_r = acc & KEEP_MASK;
				end
				return to_source();
			end
			AT_SPAN: begin
				gather(b);
				if (fcount < 4'd2)
					return GO_ON;
				return to_src_addr();
			end
			AT_SADDR: begin
				gather(b);
				if (fcount < addr_bytes_of(smode))
					return GO_ON;
				if (smode == mhp_pkg::AM_SHORT) begin
					if (acc[15:0] == mhp_pkg::BROADCAST)
						return int'(mhp_pkg::ST_BCAST_SRC);
					if (ADDR_BYTES == 8)
						return int'(mhp_pkg::ST_BAD_MODE);
					src_r = acc;
				end else begin
					src_r = acc & KEEP_MASK;
				end
				return to_security();
			end
			AT_SECCTL: begin
				level_r = b[2:0];
				if (keys_cfg) begin
					if (b[4:3] > 2'd1)
						return int'(mhp_pkg::ST_BAD_KEY);
					keymode_r = b[3];
				end
				open_field(AT_COUNTER);
				return GO_ON;
			end
			AT_COUNTER: begin
				gather(b);
				if (fcount < 4'd4)
					return GO_ON;
				counter_r = acc[31:0];
				if (keymode_r) begin
					stage = AT_KEYIDX;
					return GO_ON;
				end
				return int'(mhp_pkg::ST_OK);
			end
			AT_KEYIDX: begin
				keyidx_r = b;
				return int'(mhp_pkg::ST_OK);
			end
			default: return GO_ON;
		endcase
	endfunction

	function automatic void queue_header(logic [2:0] st);
		mhp_pkg::hdr_item_t h;
		h.status        = st;
		h.frame_type    = ctl[2:0];
		h.pending       = ctl[4];
		h.ack_request   = ctl[5];
		h.seq_num       = seq_r;
		h.dst_addr      = dst_r;
		h.src_addr      = src_r;
		h.sec_level     = level_r;
		h.key_mode      = keymode_r;
		h.key_index     = keyidx_r;
		h.frame_counter = counter_r;
		h.hdr_bytes     = pos;
		headers_due.push_back(h);
	endfunction

	task automatic predict_byte(mhp_pkg::byte_item_t it);
		int verdict;
		if (stage != AT_DONE) begin
			pos = pos + 5'd1;
			verdict = parse_byte(it.frame_byte);
			if (verdict >= 0) begin
				stage = AT_DONE;
				queue_header(verdict[2:0]);
			end else if (it.last_byte) begin
				queue_header(mhp_pkg::ST_TRUNC);
			end
		end
		// the last byte always rearms the parse
		if (it.last_byte)
			clear_frame();
	endtask

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fails++;
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("header %0d %s: got %0h, expected %0h", hdr_seen, name, got, want));
	endtask

	task automatic check_header(mhp_pkg::hdr_item_t got);
		mhp_pkg::hdr_item_t want;
		hdr_seen++;
		if (headers_due.size() == 0) begin
			report($sformatf("header %0d arrived with none due, status %0d",
				hdr_seen, got.status));
			return;
		end
		want = headers_due.pop_front();
		compare_field("status", 64'(got.status), 64'(want.status));
		compare_field("frame_type", 64'(got.frame_type), 64'(want.frame_type));
		compare_field("pending", 64'(got.pending), 64'(want.pending));
		compare_field("ack_request", 64'(got.ack_request), 64'(want.ack_request));
		compare_field("seq_num", 64'(got.seq_num), 64'(want.seq_num));
		compare_field("dst_addr", got.dst_addr, want.dst_addr);
		compare_field("src_addr", got.src_addr, want.src_addr);
		compare_field("sec_level", 64'(got.sec_level), 64'(want.sec_level));
		compare_field("key_mode", 64'(got.key_mode), 64'(want.key_mode));
		compare_field("key_index", 64'(got.key_index), 64'(want.key_index));
		compare_field("frame_counter", 64'(got.frame_counter), 64'(want.frame_counter));
		compare_field("hdr_bytes", 64'(got.hdr_bytes), 64'(want.hdr_bytes));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_cfg = 16'hABCD;
			aux_cfg = 1'b1;
			keys_cfg = 1'b1;
			clear_frame();
			headers_due.delete();
			hdr_seen = 0;
			fails = 0;
			owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					mhp_pkg::CFG_PAN_ID:       pan_cfg = cfg_data;
					mhp_pkg::CFG_AUX_HEADER:   aux_cfg = cfg_data[0];
					mhp_pkg::CFG_EXPLICIT_KEY: keys_cfg = cfg_data[0];
					default: ;
				endcase
			end
			if (hdr_valid && hdr_ready)
				check_header(hdr_data);
			if (byte_valid && byte_ready)
				predict_byte(byte_data);
			owed <= headers_due.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Top of the header parser bench. Drives frame bytes and configuration writes,
// throttles the result side, and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module testbench;

	localparam int unsigned ADDR_BYTES = 8;
	// generous: well beyond what the slowest correct run needs
	localparam int CYCLE_LIMIT = 200000;
	// a result passes the input and result registers after its byte; allow for a stalled result too
	localparam int SETTLE = 8;
	localparam int PHASE_BYTES = 100;
	localparam int PHASE_FRAMES = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_ready;
	mhp_pkg::byte_item_t byte_data = '0;
	logic                hdr_valid;
	logic                hdr_ready = 1'b0;
	mhp_pkg::hdr_item_t  hdr_data;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_addr = mhp_pkg::CFG_PAN_ID;
	logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fails, owed;
	// percentages of cycles in which the sender idles or the receiver stalls
	int src_idle = 0;
	int sink_stall = 0;
	int bytes_sent = 0;
	logic [15:0] own_pan = 16'hABCD;
	logic [7:0]  frame_q[$];

	mac_header_parser #(.ADDR_BYTES(ADDR_BYTES)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.hdr_valid  (hdr_valid),
		.hdr_ready  (hdr_ready),
		.hdr_data   (hdr_data),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data)
	);

	mhp_checker #(.ADDR_BYTES(ADDR_BYTES)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.hdr_valid  (hdr_valid),
		.hdr_ready  (hdr_ready),
		.hdr_data   (hdr_data),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.owed       (owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: decide afresh every cycle whether to take a header transfer.
	always @(posedge clk) begin
		hdr_ready <= ($urandom_range(99) >= sink_stall);
	end

	// Offer one byte, idling first at the current rate, and hold it until the
	// transfer happens. Valid is left high so back-to-back bytes need no gap.
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < src_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{frame_byte: b, last_byte: last};
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
	endtask

	// Append a field least significant byte first, as it goes over the air.
	task automatic push_le(logic [63:0] v, int n);
		for (int i = 0; i < n; i++)
			frame_q.push_back(v[8*i +: 8]);
	endtask

	task automatic send_queued();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic send_fixed(logic [63:0] v, int n);
		frame_q.delete();
		push_le(v, n);
		send_queued();
	endtask

	// Mostly the modes that get past the addressing checks; reserved seldom.
	function automatic logic [1:0] pick_mode();
		case ($urandom_range(9))
			0:       return mhp_pkg::AM_RESERVED;
			1, 2:    return mhp_pkg::AM_NONE;
			3, 4, 5: return mhp_pkg::AM_SHORT;
			default: return mhp_pkg::AM_LONG;
		endcase
	endfunction

	function automatic logic [15:0] pick_pan();
		case ($urandom_range(5))
			0:       return mhp_pkg::BROADCAST;
			1:       return 16'($urandom);
			default: return own_pan;
		endcase
	endfunction

	// Build one frame into frame_q: mostly a well-formed header with random
	// content and a short payload, sometimes cut short, now and then pure noise.
	task automatic build_frame();
		logic [7:0] fc0, fc1, sec;
		logic [1:0] dm, sm;
		int cut;
		frame_q.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 30))
				frame_q.push_back(8'($urandom));
			return;
		end
		dm = pick_mode();
		sm = pick_mode();
		fc0 = 8'($urandom);
		fc0[3] = ($urandom_range(2) != 0);
		fc1 = 8'($urandom);
		fc1[3:2] = dm;
		fc1[7:6] = sm;
		frame_q.push_back(fc0);
		frame_q.push_back(fc1);
		frame_q.push_back(8'($urandom));
		if (dm != mhp_pkg::AM_NONE) begin
			push_le({48'd0, pick_pan()}, 2);
			if (dm == mhp_pkg::AM_LONG)
				push_le({$urandom, $urandom}, 8);
			else if ($urandom_range(3) != 0)
				push_le({48'd0, mhp_pkg::BROADCAST}, 2);
			else
				push_le({32'd0, $urandom}, 2);
		end
		if (sm != mhp_pkg::AM_NONE) begin
			// source PAN only travels when not compressed
			if (!fc0[6])
				push_le({32'd0, $urandom}, 2);
			if (sm == mhp_pkg::AM_LONG)
				push_le({$urandom, $urandom}, 8);
			else if ($urandom_range(3) == 0)
				push_le({48'd0, mhp_pkg::BROADCAST}, 2);
			else
				push_le({32'd0, $urandom}, 2);
		end
		if (fc0[3]) begin
			sec = 8'($urandom);
			if ($urandom_range(7) == 0)
				sec[4:3] = 2'($urandom_range(2, 3));
			else
				sec[4:3] = 2'($urandom_range(1));
			frame_q.push_back(sec);
			push_le({32'd0, $urandom}, 4);
			if (sec[4:3] == 2'd1)
				frame_q.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 4))
			frame_q.push_back(8'($urandom));
		if ($urandom_range(5) == 0) begin
			cut = $urandom_range(1, frame_q.size());
			while (frame_q.size() > cut)
				void'(frame_q.pop_back());
		end
	endtask

	// Hold the sender until every header due has come, then let the pipeline
	// settle so that a byte still in flight cannot see a register change.
	task automatic drain();
		byte_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	initial begin
		int start, frames;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone byte that is also the last: truncated at the frame control
		send_fixed(64'hFF, 1);
		// short destination under a foreign PAN, then one trailing byte
		send_fixed(64'h00_12_34_00_08_00, 6);
		// broadcast PAN and address, header ends exactly on the last byte
		send_fixed(64'hFF_FF_FF_FF_FF_08_07, 7);
		// reserved destination mode, reported after the PAN matches
		send_fixed(64'h00_AB_CD_00_04_00, 6);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				1: begin
					own_pan = 16'h0000;
					write_reg(mhp_pkg::CFG_PAN_ID, own_pan);
					write_reg(mhp_pkg::CFG_AUX_HEADER, 16'd1);
					write_reg(mhp_pkg::CFG_EXPLICIT_KEY, 16'd0);
					src_idle = 47;
					sink_stall = 0;
				end
				2: begin
					own_pan = 16'hFFFF;
					write_reg(mhp_pkg::CFG_PAN_ID, own_pan);
					write_reg(mhp_pkg::CFG_AUX_HEADER, 16'd0);
					write_reg(mhp_pkg::CFG_EXPLICIT_KEY, 16'd1);
					src_idle = 0;
					sink_stall = 47;
				end
				3: begin
					own_pan = 16'($urandom);
					write_reg(mhp_pkg::CFG_PAN_ID, own_pan);
					write_reg(mhp_pkg::CFG_AUX_HEADER, 16'd1);
					write_reg(mhp_pkg::CFG_EXPLICIT_KEY, 16'd1);
					src_idle = 20;
					sink_stall = 20;
				end
				default: begin
					// reset settings, no idling on either side
					src_idle = 0;
					sink_stall = 0;
				end
			endcase
			cfg_we <= 1'b0;
			start = bytes_sent;
			frames = 0;
			while (bytes_sent - start < PHASE_BYTES || frames < PHASE_FRAMES) begin
				build_frame();
				send_queued();
				frames++;
			end
		end

		drain();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/mhp_pkg.sv
design/mhp_in_stage.sv
design/mhp_parser.sv
design/mhp_out_stage.sv
design/mac_header_parser.sv
design/mhp_checker.sv
dv/mhp_checker.sv
dv/testbench.sv
